// ===== rtl/tgst_pkg.sv =====
// ----------------------------------------------------------------------------
// tgst_pkg - shared types and constants for the group sequence tracker
// Ring geometry, counter width, register indexes and field widths.
// ----------------------------------------------------------------------------
package tgst_pkg;

	// ring geometry: depth is a power of two so the ring index is a bit slice
	localparam int RING_IDX_W  = 4;
	localparam int RING_DEPTH  = 1 << RING_IDX_W;
	localparam int COUNT_WIDTH = 32;

	localparam int SEQ_W      = 32;
	localparam int GSIZE_W    = 16;
	localparam int TBITS_W    = 4;
	localparam int WIN_W      = 8;
	localparam int ARRIVAL_W  = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam int MAX_TBITS  = 8;

	// restoring divider: one quotient bit per step
	localparam int DIV_STEPS = SEQ_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GROUP_SIZE     = 4'd0,
		REG_SEQ_BITS       = 4'd1,
		REG_FORWARD_WINDOW = 4'd2,
		REG_FLOW_LENGTH    = 4'd3
	} cfg_reg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/tgst_if.sv =====
// ----------------------------------------------------------------------------
// tgst_if - handshake channels of the group sequence tracker
// Packet input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface tgst_pkt_if;
	logic                       valid;
	logic                       ready;
	logic [tgst_pkg::SEQ_W-1:0] seq_num;

	modport source (output valid, output seq_num, input ready);
	modport sink   (input valid, input seq_num, output ready);
endinterface

interface tgst_res_if;
	logic        valid;
	logic        ready;
	logic        correct;
	logic        out_of_window;
	logic [31:0] rebuilt_group;
	logic [31:0] nonending_groups;
	logic [31:0] nonending_delay;
	logic [31:0] incomplete_delay;
	logic [31:0] incomplete_groups;

	modport source (output valid, output correct, output out_of_window,
		output rebuilt_group, output nonending_groups, output nonending_delay,
		output incomplete_delay, output incomplete_groups, input ready);
	modport sink (input valid, input correct, input out_of_window,
		input rebuilt_group, input nonending_groups, input nonending_delay,
		input incomplete_delay, input incomplete_groups, output ready);
endinterface

interface tgst_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [tgst_pkg::CFG_IDX_W-1:0]  index;
	logic [tgst_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/truncated_group_seq_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// truncated_group_seq_tracker_unit - truncated group sequence tracker
// Rebuilds the full group index from truncated bits and keeps lag statistics.
// ----------------------------------------------------------------------------
// Each packet takes two passes of the shared divider (sequence number, then flow
// length), then one lag-ageing step per entry of the backward window, then a
// retire step and an advance step per group advance.
// The tracker takes one packet at a time; a frozen tracker answers without dividing.
// Reset clears the counters, both rings and the error flag at once.
module truncated_group_seq_tracker_unit (
	input  logic       clk,
	input  logic       arst_n,
	tgst_pkt_if.sink   pkt,
	tgst_res_if.source res,
	tgst_cfg_if.sink   cfg
);
	import tgst_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV_SEQ, ST_DIV_FLOW, ST_PREP, ST_LAG,
		ST_RET, ST_ADV, ST_FINAL, ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [GSIZE_W-1:0] gsize_q;
	logic [TBITS_W-1:0] tbits_q;
	logic [WIN_W-1:0]   fwin_q;
	logic [31:0]        flow_q;

	// tracking state
	logic [31:0]             gc_q;
	logic                    err_q;
	logic [COUNT_WIDTH-1:0]  lag_q [RING_DEPTH];
	logic [ARRIVAL_W-1:0]    arr_q [RING_DEPTH];
	logic [COUNT_WIDTH-1:0]  ret_cnt_q, ret_dly_q, part_dly_q, part_cnt_q;

	// per-packet working registers
	logic [31:0]       tgrp_q;
	logic [31:0]       flq_q;
	logic [WIN_W-1:0]  mod_q;
	logic [WIN_W-1:0]  diff_q;
	logic signed [8:0] beta_q;
	logic [WIN_W-1:0]  i_q;
	logic [WIN_W-1:0]  step_q;
	logic              oow_q;
	logic [31:0]       rebuilt_q;

	// output register
	logic        res_valid_q;
	logic        o_correct_q, o_oow_q;
	logic [31:0] o_rebuilt_q, o_ngrp_q, o_ndly_q, o_idly_q, o_igrp_q;

	// divider hookup
	logic               div_start;
	logic [SEQ_W-1:0]   div_dividend;
	logic [GSIZE_W-1:0] eff_g;
	div_stat_t          div_stat;
	logic [SEQ_W-1:0]   div_quo;

	logic                   pkt_xfer;
	logic [TBITS_W-1:0]     t_eff;
	logic [WIN_W-1:0]       mod_c;
	logic [WIN_W-1:0]       diff_c;
	logic signed [8:0]      beta_c;
	logic                   go_adv_c;
	logic                   adv_path;
	logic                   go_adv;
	logic signed [33:0]     c34, beta34, lower34, grp34, calc34, end34;
	logic [WIN_W:0]         off9;
	logic [RING_IDX_W-1:0]  lag_idx, ret_idx, adv_idx, calc_idx;
	logic                   ret_take, ret_part;
	logic                   load_out;

	assign pkt.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign pkt_xfer  = pkt.valid && pkt.ready;

	assign eff_g = (gsize_q == '0) ? GSIZE_W'(1) : gsize_q;
	assign t_eff = (tbits_q > TBITS_W'(MAX_TBITS)) ? TBITS_W'(MAX_TBITS) : tbits_q;
	assign mod_c = WIN_W'((9'd1 << t_eff) - 9'd1);

	// window set-up for the packet, taken before the working registers load
	assign diff_c   = (tgrp_q[WIN_W-1:0] - gc_q[WIN_W-1:0]) & mod_c;
	assign beta_c   = signed'({1'b0, mod_c}) - signed'({1'b0, fwin_q});
	assign go_adv_c = (diff_c <= fwin_q) && (diff_c != '0);

	// start the divider on the sequence number, then on the flow length
	assign div_start    = (pkt_xfer && !err_q) || (state_q == ST_DIV_SEQ && div_stat.done);
	assign div_dividend = (state_q == ST_IDLE) ? pkt.seq_num : flow_q;

	tgst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (eff_g),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// window arithmetic on the unwrapped counter
	assign c34      = signed'({2'b00, gc_q});
	assign beta34   = 34'(beta_q);
	assign lower34  = c34 - beta34;
	assign adv_path = diff_q <= fwin_q;
	assign go_adv   = adv_path && (diff_q != '0);
	assign off9     = ({1'b0, mod_q} + 9'd1 - {1'b0, diff_q}) & {1'b0, mod_q};
	assign calc34   = adv_path ? c34 : c34 - signed'({25'd0, off9});

	// retire test: group c - beta, compared with gamma added
	assign grp34    = lower34;
	assign end34    = grp34 + signed'({26'd0, fwin_q});
	assign ret_idx  = grp34[RING_IDX_W-1:0];
	assign ret_take = !grp34[33] && (end34 < signed'({2'b00, flq_q}));
	assign ret_part = arr_q[ret_idx] != eff_g;

	assign lag_idx  = gc_q[RING_IDX_W-1:0] - i_q[RING_IDX_W-1:0];
	assign adv_idx  = gc_q[RING_IDX_W-1:0] + 1'b1;
	assign calc_idx = calc34[RING_IDX_W-1:0];

	assign load_out = (state_q == ST_DONE) && (!res_valid_q || res.ready);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gsize_q <= GSIZE_W'(1);
			tbits_q <= TBITS_W'(4);
			fwin_q  <= WIN_W'(4);
			flow_q  <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_GROUP_SIZE:     gsize_q <= cfg.data[GSIZE_W-1:0];
				REG_SEQ_BITS:       tbits_q <= cfg.data[TBITS_W-1:0];
				REG_FORWARD_WINDOW: fwin_q  <= cfg.data[WIN_W-1:0];
				REG_FLOW_LENGTH:    flow_q  <= cfg.data[31:0];
				default: ;
			endcase
		end
	end

	// sequencer, rings and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			gc_q       <= '0;
			err_q      <= 1'b0;
			ret_cnt_q  <= '0;
			ret_dly_q  <= '0;
			part_dly_q <= '0;
			part_cnt_q <= '0;
			for (int k = 0; k < RING_DEPTH; k++) begin
				lag_q[k] <= '0;
				arr_q[k] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pkt_xfer) begin
						state_q <= err_q ? ST_DONE : ST_DIV_SEQ;
					end
				end
				ST_DIV_SEQ: begin
					if (div_stat.done) begin
						state_q <= ST_DIV_FLOW;
					end
				end
				ST_DIV_FLOW: begin
					if (div_stat.done) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (!beta_c[8]) begin
						state_q <= ST_LAG;
					end else begin
						state_q <= go_adv_c ? ST_RET : ST_FINAL;
					end
				end
				ST_LAG: begin
					// age one group behind the counter per cycle
					if (gc_q >= {24'd0, i_q}) begin
						lag_q[lag_idx] <= lag_q[lag_idx] + 1'b1;
					end
					if (i_q == beta_q[WIN_W-1:0]) begin
						state_q <= go_adv ? ST_RET : ST_FINAL;
					end
				end
				ST_RET: begin
					// retire the group leaving the backward window
					if (ret_take) begin
						ret_cnt_q <= ret_cnt_q + 1'b1;
						ret_dly_q <= ret_dly_q + lag_q[ret_idx];
						if (ret_part) begin
							part_dly_q <= part_dly_q + lag_q[ret_idx];
							part_cnt_q <= part_cnt_q + 1'b1;
						end
					end
					state_q <= ST_ADV;
				end
				ST_ADV: begin
					// advance the counter and open a fresh ring entry
					gc_q           <= gc_q + 1'b1;
					lag_q[adv_idx] <= '0;
					arr_q[adv_idx] <= '0;
					state_q        <= (step_q + 1'b1 == diff_q) ? ST_FINAL : ST_RET;
				end
				ST_FINAL: begin
					if (calc34 < lower34 || calc34[33]) begin
						err_q <= 1'b1;
					end else begin
						lag_q[calc_idx] <= '0;
						arr_q[calc_idx] <= arr_q[calc_idx] + 1'b1;
						if (calc34 != signed'({2'b00, tgrp_q})) begin
							err_q <= 1'b1;
						end
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-packet working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				oow_q     <= 1'b0;
				rebuilt_q <= '0;
			end
			ST_DIV_SEQ: begin
				if (div_stat.done) begin
					tgrp_q <= div_quo;
				end
			end
			ST_DIV_FLOW: begin
				if (div_stat.done) begin
					flq_q <= div_quo;
				end
			end
			ST_PREP: begin
				mod_q  <= mod_c;
				diff_q <= diff_c;
				beta_q <= beta_c;
				i_q    <= '0;
				step_q <= '0;
			end
			ST_LAG: i_q <= i_q + 1'b1;
			ST_ADV: step_q <= step_q + 1'b1;
			ST_FINAL: begin
				if (calc34 < lower34) begin
					oow_q     <= 1'b1;
					rebuilt_q <= calc34[31:0];
				end else if (!calc34[33]) begin
					rebuilt_q <= calc34[31:0];
				end
			end
			default: ;
		endcase
	end

	// output register: hold the result until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			o_correct_q <= !err_q;
			o_oow_q     <= oow_q;
			o_rebuilt_q <= rebuilt_q;
			o_ngrp_q    <= 32'(ret_cnt_q);
			o_ndly_q    <= 32'(ret_dly_q);
			o_idly_q    <= 32'(part_dly_q);
			o_igrp_q    <= 32'(part_cnt_q);
		end
	end

	assign res.valid             = res_valid_q;
	assign res.correct           = o_correct_q;
	assign res.out_of_window     = o_oow_q;
	assign res.rebuilt_group     = o_rebuilt_q;
	assign res.nonending_groups  = o_ngrp_q;
	assign res.nonending_delay   = o_ndly_q;
	assign res.incomplete_delay  = o_idly_q;
	assign res.incomplete_groups = o_igrp_q;

	// the error flag is sticky until reset
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q) else $error("error flag cleared without reset");

	// the group counter moves only on an advance step
	a_gc_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ADV) |=> $stable(gc_q)) else $error("counter moved outside advance");

	// an out-of-window result always reports a lost reconstruction
	a_oow_err: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.out_of_window) |-> !res.correct)
		else $error("out-of-window result flagged correct");

	// the divider is only started when free
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (!div_stat.busy)) else $error("divider restarted while busy");

endmodule

// ===== rtl/tgst_div.sv =====
// ----------------------------------------------------------------------------
// tgst_div - iterative unsigned divider
// Restoring division of a 32-bit value by a 16-bit value, one bit per cycle.
// ----------------------------------------------------------------------------
module tgst_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [tgst_pkg::SEQ_W-1:0]     dividend,
	input  logic [tgst_pkg::GSIZE_W-1:0]   divisor,
	output tgst_pkg::div_stat_t            stat,
	output logic [tgst_pkg::SEQ_W-1:0]     quotient
);
	import tgst_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [GSIZE_W-1:0]   rem_q;
	logic [SEQ_W-1:0]     quo_q;
	logic [GSIZE_W:0]     shifted;
	logic                 fits;

	// trial subtract of the shifted remainder
	assign shifted = {rem_q, quo_q[SEQ_W-1]};
	assign fits    = shifted >= {1'b0, divisor};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift in one quotient bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? GSIZE_W'(shifted - {1'b0, divisor}) : shifted[GSIZE_W-1:0];
			quo_q <= {quo_q[SEQ_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - testbench of the truncated group sequence tracker
// Sends packet sequence numbers in bursts, holds the result channel back on a
// changing stall pattern, and checks every result against an in-bench
// prediction of group rebuilding, lag ageing and retirement statistics.
// Register settings change between phases while the tracker is idle.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tgst_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd5;
	localparam longint MASK32 = 64'h0000_0000_FFFF_FFFF;
	localparam int CFG_SETTLE = 20;
	localparam int END_WAIT = 1000;
	localparam longint CYCLE_LIMIT = 6_000_000;

	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [31:0]          data;
		logic [31:0]          seq;
	} op_t;

	typedef struct {
		logic        correct;
		logic        out_of_window;
		logic [31:0] rebuilt_group;
		logic [31:0] nonending_groups;
		logic [31:0] nonending_delay;
		logic [31:0] incomplete_delay;
		logic [31:0] incomplete_groups;
	} track_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tgst_pkt_if pkt ();
	tgst_res_if res ();
	tgst_cfg_if cfg ();

	truncated_group_seq_tracker_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt),
		.res    (res),
		.cfg    (cfg)
	);

	always #5 clk = ~clk;

	// pending stimulus and expected tracker results
	op_t        pending_ops[$];
	track_res_t expected_res[$];
	int         err_count = 0;
	int         pkt_count = 0;
	int         res_count = 0;
	int         cfg_count = 0;
	int         oow_seen = 0;
	longint     cycle_count = 0;
	bit         stim_done = 0;

	// tracker shadow: registers and state
	logic [15:0] sh_gsize = 16'd1;
	logic [3:0]  sh_tbits = 4'd4;
	logic [7:0]  sh_fwin = 8'd4;
	logic [31:0] sh_flow = 32'd0;
	longint      sh_counter = 0;
	logic [31:0] sh_lag[RING_DEPTH];
	logic [15:0] sh_arrivals[RING_DEPTH];
	bit          sh_frozen = 0;
	logic [31:0] sh_ret_cnt = 0, sh_ret_dly = 0, sh_part_dly = 0, sh_part_cnt = 0;

	initial begin
		for (int i = 0; i < RING_DEPTH; i++) begin
			sh_lag[i] = '0;
			sh_arrivals[i] = '0;
		end
	end

	// add a retired group to the statistics when it is not near the flow end
	function automatic void retire_grp(longint grp, longint gam);
		longint g;
		int k;
		g = (sh_gsize == 0) ? 1 : sh_gsize;
		k = int'(grp % RING_DEPTH);
		if (grp + gam < longint'(sh_flow) / g) begin
			sh_ret_cnt += 1;
			sh_ret_dly += sh_lag[k];
			if (longint'(sh_arrivals[k]) != g) begin
				sh_part_dly += sh_lag[k];
				sh_part_cnt += 1;
			end
		end
	endfunction

	// rebuild the group of one packet and age the rings
	function automatic track_res_t rebuild_group(logic [31:0] seq);
		track_res_t r;
		longint g, t, md, gam, bet, tg, diff, c, calc;
		int k;
		r.out_of_window = 1'b0;
		r.rebuilt_group = '0;
		if (!sh_frozen) begin
			g = (sh_gsize == 0) ? 1 : sh_gsize;
			t = (sh_tbits > MAX_TBITS) ? MAX_TBITS : sh_tbits;
			md = (longint'(1) << t) - 1;
			gam = sh_fwin;
			bet = md - gam;
			tg = longint'(seq) / g;
			diff = ((tg & md) - (sh_counter & md)) & md;
			c = sh_counter;
			for (longint i = 0; i <= bet; i++)
				if (c >= i) sh_lag[int'((c - i) % RING_DEPTH)] += 1;
			if (diff <= gam) begin
				for (longint i = 0; i < diff; i++) begin
					c = sh_counter;
					if (c - bet >= 0) retire_grp(c - bet, gam);
					sh_counter = (sh_counter + 1) & MASK32;
					sh_lag[int'(sh_counter % RING_DEPTH)] = '0;
					sh_arrivals[int'(sh_counter % RING_DEPTH)] = '0;
				end
				c = sh_counter;
				calc = c;
			end else begin
				calc = c - ((md + 1 - diff) & md);
			end
			if (calc < c - bet) begin
				sh_frozen = 1;
				r.out_of_window = 1'b1;
				r.rebuilt_group = 32'(calc & MASK32);
			end else if (calc < 0) begin
				sh_frozen = 1;
			end else begin
				k = int'(calc % RING_DEPTH);
				sh_lag[k] = '0;
				sh_arrivals[k] += 1;
				r.rebuilt_group = 32'(calc & MASK32);
				if (calc != tg) sh_frozen = 1;
			end
		end
		r.correct = !sh_frozen;
		r.nonending_groups = sh_ret_cnt;
		r.nonending_delay = sh_ret_dly;
		r.incomplete_delay = sh_part_dly;
		r.incomplete_groups = sh_part_cnt;
		return r;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
		case (idx)
			REG_GROUP_SIZE:     sh_gsize = d[15:0];
			REG_SEQ_BITS:       sh_tbits = d[3:0];
			REG_FORWARD_WINDOW: sh_fwin = d[7:0];
			REG_FLOW_LENGTH:    sh_flow = d;
			default: ;
		endcase
	endfunction

	// stimulus planning view: effective settings and highest group sent
	longint plan_g = 1, plan_mod = 15, plan_gam = 4, plan_top = 0;
	logic [3:0] plan_tbits = 4'd4;

	task automatic queue_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
		op_t o;
		o.is_cfg = 1;
		o.idx = idx;
		o.data = d;
		o.seq = '0;
		pending_ops.push_back(o);
		case (idx)
			REG_GROUP_SIZE:     plan_g = (d[15:0] == 0) ? 1 : d[15:0];
			REG_SEQ_BITS:       plan_tbits = d[3:0];
			REG_FORWARD_WINDOW: plan_gam = d[7:0];
			default: ;
		endcase
		plan_mod = (longint'(1) << ((plan_tbits > MAX_TBITS) ? MAX_TBITS : plan_tbits)) - 1;
	endtask

	task automatic queue_seq(logic [31:0] s);
		op_t o;
		o.is_cfg = 0;
		o.idx = '0;
		o.data = '0;
		o.seq = s;
		pending_ops.push_back(o);
	endtask

	// set the flow end a random number of groups past the present top group
	task automatic queue_flow();
		longint f;
		f = (plan_top + $urandom_range(0, 300)) * plan_g;
		if (f > MASK32) f = MASK32;
		queue_reg(REG_FLOW_LENGTH, 32'(f));
	endtask

	// well-formed packets: advances inside gamma, late packets inside beta
	task automatic queue_items(int n, bit far_jumps);
		longint bet, grp, s;
		int pick;
		bet = plan_mod - plan_gam;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			grp = plan_top;
			if (pick < 65 && plan_gam > 0) begin
				if (far_jumps)
					grp = plan_top + $urandom_range(int'(plan_gam / 2), int'(plan_gam));
				else if (pick < 30)
					grp = plan_top + 1;
				else
					grp = plan_top + $urandom_range(0, int'(plan_gam));
			end else if (pick < 92 && bet > 0 && plan_top > 0) begin
				grp = plan_top - $urandom_range(1, int'((bet < plan_top) ? bet : plan_top));
			end
			s = grp * plan_g + $urandom_range(0, int'(plan_g - 1));
			if (s > MASK32) begin
				grp = plan_top;
				s = MASK32;
				if (s / plan_g != grp) s = grp * plan_g;
			end
			if (grp > plan_top) plan_top = grp;
			queue_seq(32'(s));
		end
	endtask

	// stimulus plan
	initial begin
		longint s;
		// defaults: one packet per group, four bits carried, window four ahead
		queue_seq(32'd0);
		queue_seq(32'd1);
		queue_seq(32'd4);
		queue_seq(32'd2);
		queue_seq(32'd8);
		queue_seq(32'd8);
		queue_seq(32'd12);
		queue_seq(32'd1);
		queue_seq(32'd16);
		queue_seq(32'd5);
		plan_top = 16;
		// zero group size acts as one, no index bits carried
		queue_reg(REG_GROUP_SIZE, 32'd0);
		queue_reg(REG_SEQ_BITS, 32'd0);
		queue_reg(REG_FORWARD_WINDOW, 32'd0);
		queue_reg(REG_FLOW_LENGTH, 32'd0);
		queue_reg(REG_UNUSED, 32'hFFFF_FFFF);
		for (int i = 0; i < 4; i++) queue_seq(32'(plan_top));
		// small groups, moderate window
		queue_reg(REG_GROUP_SIZE, 32'd3);
		queue_reg(REG_SEQ_BITS, 32'd4);
		queue_reg(REG_FORWARD_WINDOW, 32'd6);
		queue_flow();
		queue_items(200, 0);
		// oversized bit count acts as eight, deep backward window
		queue_reg(REG_GROUP_SIZE, 32'd1);
		queue_reg(REG_SEQ_BITS, 32'd15);
		queue_reg(REG_FORWARD_WINDOW, 32'd0);
		queue_flow();
		queue_items(60, 0);
		// narrow windows
		queue_reg(REG_SEQ_BITS, 32'd1);
		queue_reg(REG_FORWARD_WINDOW, 32'd1);
		queue_reg(REG_GROUP_SIZE, 32'd2);
		queue_flow();
		queue_items(80, 0);
		queue_reg(REG_SEQ_BITS, 32'd2);
		queue_reg(REG_FORWARD_WINDOW, 32'd2);
		queue_items(60, 0);
		// widest forward window, no backward window
		queue_reg(REG_GROUP_SIZE, 32'd7);
		queue_reg(REG_SEQ_BITS, 32'd8);
		queue_reg(REG_FORWARD_WINDOW, 32'd255);
		queue_reg(REG_FLOW_LENGTH, 32'hFFFF_FFFF);
		queue_items(100, 0);
		queue_reg(REG_FORWARD_WINDOW, 32'd12);
		queue_flow();
		queue_items(120, 0);
		// largest groups, big jumps to reach the top of the sequence range
		queue_reg(REG_GROUP_SIZE, 32'd65535);
		queue_reg(REG_FORWARD_WINDOW, 32'd200);
		queue_flow();
		queue_items(260, 1);
		queue_reg(REG_FLOW_LENGTH, 32'hFFFF_FFFF);
		queue_seq(32'hFFFF_FFFF);
		queue_items(20, 0);
		// end with one error, then check the frozen tracker
		if ($urandom_range(0, 1) == 0) begin
			queue_reg(REG_SEQ_BITS, 32'd2);
			queue_reg(REG_FORWARD_WINDOW, 32'd10);
			queue_seq(32'(plan_top * plan_g));
		end else begin
			queue_reg(REG_GROUP_SIZE, 32'd1);
			queue_reg(REG_SEQ_BITS, 32'd3);
			queue_reg(REG_FORWARD_WINDOW, 32'd3);
			s = plan_top + 8;
			queue_seq(32'(s));
		end
		for (int i = 0; i < 3; i++) queue_seq($urandom());
		stim_done = 1;
	end

	// reset and clock limit
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_res.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// transfers seen at the rising edge
	bit pkt_took = 0, cfg_took = 0;

	// monitor: predict on packet transfer, check on result transfer
	always @(posedge clk) begin
		track_res_t e;
		pkt_took = pkt.valid && pkt.ready;
		cfg_took = cfg.valid && cfg.ready;
		if (arst_n && res.valid && res.ready) begin
			res_count++;
			if (res.out_of_window === 1'b1) oow_seen++;
			if (expected_res.size() == 0) begin
				$error("result with no expectation waiting");
				err_count++;
			end else begin
				e = expected_res.pop_front();
				if (res.correct !== e.correct) begin
					$error("correct: expected %0d actual %0d", e.correct, res.correct);
					err_count++;
				end
				if (res.out_of_window !== e.out_of_window) begin
					$error("out_of_window: expected %0d actual %0d",
						e.out_of_window, res.out_of_window);
					err_count++;
				end
				if (res.rebuilt_group !== e.rebuilt_group) begin
					$error("rebuilt_group: expected %0h actual %0h",
						e.rebuilt_group, res.rebuilt_group);
					err_count++;
				end
				if (res.nonending_groups !== e.nonending_groups) begin
					$error("nonending_groups: expected %0h actual %0h",
						e.nonending_groups, res.nonending_groups);
					err_count++;
				end
				if (res.nonending_delay !== e.nonending_delay) begin
					$error("nonending_delay: expected %0h actual %0h",
						e.nonending_delay, res.nonending_delay);
					err_count++;
				end
				if (res.incomplete_delay !== e.incomplete_delay) begin
					$error("incomplete_delay: expected %0h actual %0h",
						e.incomplete_delay, res.incomplete_delay);
					err_count++;
				end
				if (res.incomplete_groups !== e.incomplete_groups) begin
					$error("incomplete_groups: expected %0h actual %0h",
						e.incomplete_groups, res.incomplete_groups);
					err_count++;
				end
			end
		end
		if (arst_n && pkt_took) begin
			pkt_count++;
			expected_res.push_back(rebuild_group(pkt.seq_num));
		end
		if (arst_n && cfg_took) begin
			cfg_count++;
			apply_reg(cfg.index, cfg.data);
		end
	end

	// driver: bursts with gaps, register writes only once the tracker is idle
	int burst_left = 0, gap_left = 0, settle = 0;

	initial begin
		pkt.valid = 1'b0;
		pkt.seq_num = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		res.ready = 1'b0;
	end

	always @(negedge clk) begin
		logic pv, cv;
		op_t o;
		pv = pkt.valid && !pkt_took;
		cv = cfg.valid && !cfg_took;
		if (arst_n && !pv && !cv && pending_ops.size() > 0) begin
			o = pending_ops[0];
			if (o.is_cfg) begin
				// hold off until every expected result has come back
				if (expected_res.size() != 0 || pkt.valid) begin
					settle = 0;
				end else if (settle < CFG_SETTLE) begin
					settle++;
				end else begin
					void'(pending_ops.pop_front());
					cv = 1'b1;
					cfg.index <= o.idx;
					cfg.data <= o.data;
					settle = 0;
				end
			end else if (gap_left > 0) begin
				gap_left--;
			end else begin
				void'(pending_ops.pop_front());
				pv = 1'b1;
				pkt.seq_num <= o.seq;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
		pkt.valid <= pv;
		cfg.valid <= cv;
	end

	// receiver: stall pattern chosen by bits 9:8 of the cycle count
	always @(negedge clk) begin
		case (cycle_count[9:8])
			2'd0: res.ready <= 1'b1;
			2'd1: res.ready <= ($urandom_range(0, 1) == 1);
			2'd2: res.ready <= (cycle_count[1:0] == 2'd3);
			default: res.ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// end of run
	initial begin
		wait (stim_done);
		wait (arst_n);
		while (pending_ops.size() != 0 || pkt.valid || cfg.valid) @(posedge clk);
		while (expected_res.size() != 0) @(posedge clk);
		repeat (END_WAIT) @(posedge clk);
		$display("Run covered %0d packets, %0d results, %0d register writes",
			pkt_count, res_count, cfg_count);
		$display("Out-of-window results seen: %0d, cycles: %0d", oow_seen, cycle_count);
		if (err_count == 0 && expected_res.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
